### hw/rtl/tsfd_pkg.sv
// ----------------------------------------------------------------------------
// tsfd_pkg
// Shared types and constants of the tactile sensor frame decoder: frame
// layout positions, fixed byte codes, status codes and inter-module structs.
// ----------------------------------------------------------------------------
package tsfd_pkg;

    localparam int TAXEL_COUNT = 25;
    localparam int FRAME_BYTES = 96;

    localparam int POS_W   = 7;
    localparam int TIDX_W  = 5;
    localparam int DATA_W  = 8;
    localparam int FIELD_W = 24;
    localparam int FORCE_W = 16;
    localparam int DIR_W   = 9;
    localparam int SUM_W   = 16;

    localparam logic [TIDX_W-1:0] LAST_TAXEL = TIDX_W'(TAXEL_COUNT - 1);

    // Frame layout (byte positions)
    localparam logic [POS_W-1:0] POS_SYNC0       = 7'd0;
    localparam logic [POS_W-1:0] POS_SYNC1       = 7'd1;
    localparam logic [POS_W-1:0] POS_ADDR        = 7'd2;
    localparam logic [POS_W-1:0] POS_CMD         = 7'd3;
    localparam logic [POS_W-1:0] POS_CHAN        = 7'd5;
    localparam logic [POS_W-1:0] POS_TAXEL_FIRST = 7'd6;
    localparam logic [POS_W-1:0] POS_TAXEL_LAST  = POS_W'(6 + 3 * TAXEL_COUNT - 1);
    localparam logic [POS_W-1:0] POS_PROX_RAW    = 7'd81;
    localparam logic [POS_W-1:0] POS_NORMAL      = 7'd84;
    localparam logic [POS_W-1:0] POS_TANGENT     = 7'd86;
    localparam logic [POS_W-1:0] POS_DIR         = 7'd88;
    localparam logic [POS_W-1:0] POS_PROX_DELTA  = 7'd90;
    localparam logic [POS_W-1:0] POS_SUM         = 7'd94;
    localparam logic [POS_W-1:0] POS_MAX         = 7'd127;
    localparam logic [POS_W-1:0] FRAME_LEN       = POS_W'(FRAME_BYTES);

    localparam logic [DATA_W-1:0] SYNC0_CODE   = 8'h55;
    localparam logic [DATA_W-1:0] SYNC1_CODE   = 8'hAA;
    localparam logic [DATA_W-1:0] CMD_CODE     = 8'h85;
    localparam logic [DATA_W-1:0] CHANNEL_CODE = 8'h1A;

    localparam logic [SUM_W-1:0] DIR_MAX = 16'd359;

    // Configuration register indexes
    localparam logic [1:0] CFG_EXPECTED = 2'd0;
    localparam logic [1:0] CFG_ACCEPT_A = 2'd1;
    localparam logic [1:0] CFG_ACCEPT_B = 2'd2;

    localparam logic [DATA_W-1:0] EXPECTED_RESET = 8'd36;
    localparam logic [DATA_W-1:0] ACCEPT_A_RESET = 8'd36;
    localparam logic [DATA_W-1:0] ACCEPT_B_RESET = 8'd37;

    typedef enum logic [2:0] {
        ST_OK,
        ST_ADDRESS,
        ST_LENGTH,
        ST_HEADER,
        ST_COMMAND,
        ST_CHANNEL,
        ST_CHECKSUM
    } status_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_FAIL,
        SEQ_FETCH,
        SEQ_SHOW
    } seq_state_t;

    typedef struct packed {
        logic [DATA_W-1:0] expected;
        logic [DATA_W-1:0] accept_a;
        logic [DATA_W-1:0] accept_b;
    } cfg_t;

    typedef struct packed {
        logic    valid;
        status_t status;
    } frame_done_t;

    typedef struct packed {
        logic [FIELD_W-1:0] prox_raw;
        logic [FIELD_W-1:0] prox_delta;
        logic [FORCE_W-1:0] normal;
        logic [FORCE_W-1:0] tangential;
        logic [DIR_W-1:0]   direction;
        logic               direction_valid;
    } final_fields_t;

endpackage

### hw/rtl/tsfd_if.sv
// ----------------------------------------------------------------------------
// tsfd_if
// Valid/ready channels of the frame decoder: received frame bytes in,
// decoded results out.
// ----------------------------------------------------------------------------
interface tsfd_byte_if
    import tsfd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tsfd_result_if
    import tsfd_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [2:0]                status;
    logic [TIDX_W-1:0]         taxel_index;
    logic [FIELD_W-1:0]        taxel_value;
    logic [FIELD_W-1:0]        prox_level;
    logic [FIELD_W-1:0]        prox_change;
    logic signed [FORCE_W-1:0] normal_force_mn;
    logic signed [FORCE_W-1:0] tangential_force_mn;
    logic [DIR_W-1:0]          direction_deg;
    logic                      direction_valid;
    logic                      last;

    modport source (
        output valid, output status, output taxel_index, output taxel_value,
        output prox_level, output prox_change, output normal_force_mn,
        output tangential_force_mn, output direction_deg, output direction_valid,
        output last, input ready
    );
    modport sink (
        input valid, input status, input taxel_index, input taxel_value,
        input prox_level, input prox_change, input normal_force_mn,
        input tangential_force_mn, input direction_deg, input direction_valid,
        input last, output ready
    );
endinterface

### hw/rtl/tactile_sensor_frame_decoder.sv
// ----------------------------------------------------------------------------
// tactile_sensor_frame_decoder
// Decodes tactile sensor reply frames byte by byte and reports status or the
// per-taxel deltas with proximity, force and direction.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per cycle while a frame streams in. On the last
// byte the input stalls until the result burst has left: a failed frame gives
// a single status word, a good frame gives 25 taxel words, the first after a
// registered read of the store, then one word per cycle while the sink is
// ready, paced by the single read port of the taxel memory. The taxel memory
// needs no clearing after reset; configuration registers are written through
// cfg_we/cfg_index/cfg_data and an index beyond the three registers is ignored.
module tactile_sensor_frame_decoder
    import tsfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    tsfd_byte_if.sink         byte_in,
    tsfd_result_if.source     result_out
);

    cfg_t               cfg_reg, cfg_next;
    logic               seq_idle;
    logic               ram_we;
    logic [TIDX_W-1:0]  ram_waddr;
    logic [FIELD_W-1:0] ram_wdata;
    logic               ram_re;
    logic [TIDX_W-1:0]  ram_raddr;
    logic [FIELD_W-1:0] ram_rdata;
    frame_done_t        done;
    final_fields_t      final_fields;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_EXPECTED: cfg_next.expected = cfg_data;
                CFG_ACCEPT_A: cfg_next.accept_a = cfg_data;
                CFG_ACCEPT_B: cfg_next.accept_b = cfg_data;
                default:      cfg_next          = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected <= EXPECTED_RESET;
            cfg_reg.accept_a <= ACCEPT_A_RESET;
            cfg_reg.accept_b <= ACCEPT_B_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tsfd_byte_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_in      (byte_in),
        .accept_en    (seq_idle),
        .cfg          (cfg_reg),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .done         (done),
        .final_fields (final_fields)
    );

    tsfd_taxel_ram u_taxel_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tsfd_result_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .done         (done),
        .final_fields (final_fields),
        .ram_rdata    (ram_rdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .idle         (seq_idle),
        .result_out   (result_out)
    );

    a_no_write_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> seq_idle && !ram_re)
        else $error("taxel store written during a result burst");

endmodule

### hw/rtl/tsfd_taxel_ram.sv
// ----------------------------------------------------------------------------
// tsfd_taxel_ram
// Taxel value store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsfd_taxel_ram
    import tsfd_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [TIDX_W-1:0]  waddr,
    input  logic [FIELD_W-1:0] wdata,
    input  logic               re,
    input  logic [TIDX_W-1:0]  raddr,
    output logic [FIELD_W-1:0] rdata
);

    logic [FIELD_W-1:0] mem [TAXEL_COUNT];
    logic [FIELD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/tsfd_byte_parser.sv
// ----------------------------------------------------------------------------
// tsfd_byte_parser
// Counts and sums incoming frame bytes, flags header faults, assembles the
// little-endian fields, writes taxels to the store and grades the frame on
// its last byte.
// ----------------------------------------------------------------------------
module tsfd_byte_parser
    import tsfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    tsfd_byte_if.sink          byte_in,
    input  logic               accept_en,
    input  cfg_t               cfg,
    output logic               ram_we,
    output logic [TIDX_W-1:0]  ram_waddr,
    output logic [FIELD_W-1:0] ram_wdata,
    output frame_done_t        done,
    output final_fields_t      final_fields
);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [SUM_W-1:0]   run_sum_reg, run_sum_next;
    logic [SUM_W-1:0]   rx_sum_reg, rx_sum_next;
    logic               hdr_fault_reg, hdr_fault_next;
    logic               cmd_fault_reg, cmd_fault_next;
    logic               chan_fault_reg, chan_fault_next;
    logic [1:0]         lane_reg, lane_next;
    logic [TIDX_W-1:0]  tidx_reg, tidx_next;
    logic [DATA_W-1:0]  b0_reg, b0_next;
    logic [DATA_W-1:0]  b1_reg, b1_next;
    logic [FIELD_W-1:0] prox_raw_reg, prox_raw_next;
    logic [FIELD_W-1:0] prox_delta_reg, prox_delta_next;
    logic [FORCE_W-1:0] normal_reg, normal_next;
    logic [FORCE_W-1:0] tangent_reg, tangent_next;
    logic [SUM_W-1:0]   dir_reg, dir_next;
    logic               accept;
    logic [DATA_W-1:0]  b;
    status_t            status;
    logic               dir_ok;

    assign byte_in.ready = accept_en;
    assign accept        = byte_in.valid && accept_en;
    assign b             = byte_in.data_byte;

    always_comb
    begin
        pos_next        = pos_reg;
        run_sum_next    = run_sum_reg;
        rx_sum_next     = rx_sum_reg;
        hdr_fault_next  = hdr_fault_reg;
        cmd_fault_next  = cmd_fault_reg;
        chan_fault_next = chan_fault_reg;
        lane_next       = lane_reg;
        tidx_next       = tidx_reg;
        b0_next         = b0_reg;
        b1_next         = b1_reg;
        prox_raw_next   = prox_raw_reg;
        prox_delta_next = prox_delta_reg;
        normal_next     = normal_reg;
        tangent_next    = tangent_reg;
        dir_next        = dir_reg;
        ram_we          = 1'b0;
        status          = ST_OK;
        done            = '0;

        if (accept)
        begin
            pos_next = (pos_reg == POS_MAX) ? pos_reg : POS_W'(pos_reg + 7'd1);
            if (pos_reg < POS_SUM)
            begin
                run_sum_next = SUM_W'(run_sum_reg + {8'd0, b});
            end
            if ((pos_reg == POS_SYNC0 && b != SYNC0_CODE) ||
                (pos_reg == POS_SYNC1 && b != SYNC1_CODE) ||
                (pos_reg == POS_ADDR && b != cfg.expected))
            begin
                hdr_fault_next = 1'b1;
            end
            if (pos_reg == POS_CMD && b != CMD_CODE)
            begin
                cmd_fault_next = 1'b1;
            end
            if (pos_reg == POS_CHAN && b != CHANNEL_CODE)
            begin
                chan_fault_next = 1'b1;
            end

            if (pos_reg inside {[POS_TAXEL_FIRST:POS_TAXEL_LAST]})
            begin
                case (lane_reg)
                    2'd0:
                    begin
                        b0_next   = b;
                        lane_next = 2'd1;
                    end
                    2'd1:
                    begin
                        b1_next   = b;
                        lane_next = 2'd2;
                    end
                    default:
                    begin
                        ram_we    = 1'b1;
                        lane_next = 2'd0;
                        tidx_next = TIDX_W'(tidx_reg + 5'd1);
                    end
                endcase
            end
            else if (pos_reg == POS_PROX_RAW || pos_reg == POS_PROX_DELTA)
            begin
                b0_next = b;
            end
            else if (pos_reg == POS_PROX_RAW + 7'd1 || pos_reg == POS_PROX_DELTA + 7'd1)
            begin
                b1_next = b;
            end
            else if (pos_reg == POS_PROX_RAW + 7'd2)
            begin
                prox_raw_next = {b, b1_reg, b0_reg};
            end
            else if (pos_reg == POS_PROX_DELTA + 7'd2)
            begin
                prox_delta_next = {b, b1_reg, b0_reg};
            end
            else if (pos_reg == POS_NORMAL)
            begin
                normal_next[7:0] = b;
            end
            else if (pos_reg == POS_NORMAL + 7'd1)
            begin
                normal_next[15:8] = b;
            end
            else if (pos_reg == POS_TANGENT)
            begin
                tangent_next[7:0] = b;
            end
            else if (pos_reg == POS_TANGENT + 7'd1)
            begin
                tangent_next[15:8] = b;
            end
            else if (pos_reg == POS_DIR)
            begin
                dir_next[7:0] = b;
            end
            else if (pos_reg == POS_DIR + 7'd1)
            begin
                dir_next[15:8] = b;
            end
            else if (pos_reg == POS_SUM)
            begin
                rx_sum_next[7:0] = b;
            end
            else if (pos_reg == POS_SUM + 7'd1)
            begin
                rx_sum_next[15:8] = b;
            end

            // grade on the updated state, including this byte
            if (cfg.expected != cfg.accept_a && cfg.expected != cfg.accept_b)
            begin
                status = ST_ADDRESS;
            end
            else if (pos_next != FRAME_LEN)
            begin
                status = ST_LENGTH;
            end
            else if (hdr_fault_next)
            begin
                status = ST_HEADER;
            end
            else if (cmd_fault_next)
            begin
                status = ST_COMMAND;
            end
            else if (chan_fault_next)
            begin
                status = ST_CHANNEL;
            end
            else if (rx_sum_next != run_sum_next)
            begin
                status = ST_CHECKSUM;
            end

            if (byte_in.last_byte)
            begin
                done.valid      = 1'b1;
                done.status     = status;
                pos_next        = '0;
                run_sum_next    = '0;
                rx_sum_next     = '0;
                hdr_fault_next  = 1'b0;
                cmd_fault_next  = 1'b0;
                chan_fault_next = 1'b0;
                lane_next       = 2'd0;
                tidx_next       = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            run_sum_reg    <= '0;
            rx_sum_reg     <= '0;
            hdr_fault_reg  <= 1'b0;
            cmd_fault_reg  <= 1'b0;
            chan_fault_reg <= 1'b0;
            lane_reg       <= 2'd0;
            tidx_reg       <= '0;
            prox_raw_reg   <= '0;
            prox_delta_reg <= '0;
            normal_reg     <= '0;
            tangent_reg    <= '0;
            dir_reg        <= '0;
        end
        else
        begin
            pos_reg        <= pos_next;
            run_sum_reg    <= run_sum_next;
            rx_sum_reg     <= rx_sum_next;
            hdr_fault_reg  <= hdr_fault_next;
            cmd_fault_reg  <= cmd_fault_next;
            chan_fault_reg <= chan_fault_next;
            lane_reg       <= lane_next;
            tidx_reg       <= tidx_next;
            prox_raw_reg   <= prox_raw_next;
            prox_delta_reg <= prox_delta_next;
            normal_reg     <= normal_next;
            tangent_reg    <= tangent_next;
            dir_reg        <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg <= b0_next;
        b1_reg <= b1_next;
    end

    assign ram_waddr = tidx_reg;
    assign ram_wdata = {b, b1_reg, b0_reg};

    assign dir_ok                       = (dir_reg <= DIR_MAX);
    assign final_fields.prox_raw        = prox_raw_reg;
    assign final_fields.prox_delta      = prox_delta_reg;
    assign final_fields.normal          = normal_reg;
    assign final_fields.tangential      = tangent_reg;
    assign final_fields.direction       = dir_ok ? dir_reg[DIR_W-1:0] : '0;
    assign final_fields.direction_valid = dir_ok;

endmodule

### hw/rtl/tsfd_result_seq.sv
// ----------------------------------------------------------------------------
// tsfd_result_seq
// Emits the result burst of a graded frame: one status word on failure, or
// the 25 taxel words read back from the store, final word carrying the
// frame-level fields.
// ----------------------------------------------------------------------------
module tsfd_result_seq
    import tsfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  frame_done_t        done,
    input  final_fields_t      final_fields,
    input  logic [FIELD_W-1:0] ram_rdata,
    output logic               ram_re,
    output logic [TIDX_W-1:0]  ram_raddr,
    output logic               idle,
    tsfd_result_if.source      result_out
);

    seq_state_t        state_reg, state_next;
    logic [TIDX_W-1:0] idx_reg, idx_next;
    status_t           status_reg, status_next;
    logic              last_idx;
    logic              out_take;

    assign last_idx = (idx_reg == LAST_TAXEL);
    assign out_take = result_out.valid && result_out.ready;

    // next state
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                idx_next = '0;
                if (done.valid)
                begin
                    status_next = done.status;
                    state_next  = (done.status == ST_OK) ? SEQ_FETCH : SEQ_FAIL;
                end
            end
            SEQ_FAIL:
            begin
                if (result_out.ready)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            SEQ_FETCH:
            begin
                state_next = SEQ_SHOW;
            end
            SEQ_SHOW:
            begin
                if (result_out.ready)
                begin
                    if (last_idx)
                    begin
                        state_next = SEQ_IDLE;
                    end
                    else
                    begin
                        idx_next = TIDX_W'(idx_reg + 5'd1);
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        idle                           = 1'b0;
        ram_re                         = 1'b0;
        ram_raddr                      = idx_reg;
        result_out.valid               = 1'b0;
        result_out.status              = ST_OK;
        result_out.taxel_index         = '0;
        result_out.taxel_value         = '0;
        result_out.prox_level          = '0;
        result_out.prox_change         = '0;
        result_out.normal_force_mn     = '0;
        result_out.tangential_force_mn = '0;
        result_out.direction_deg       = '0;
        result_out.direction_valid     = 1'b0;
        result_out.last                = 1'b0;
        case (state_reg)
            SEQ_IDLE:
            begin
                idle = 1'b1;
            end
            SEQ_FAIL:
            begin
                result_out.valid  = 1'b1;
                result_out.status = status_reg;
                result_out.last   = 1'b1;
            end
            SEQ_FETCH:
            begin
                ram_re = 1'b1;
            end
            SEQ_SHOW:
            begin
                // prefetch the next taxel as the current word leaves
                ram_re                 = result_out.ready && !last_idx;
                ram_raddr              = TIDX_W'(idx_reg + 5'd1);
                result_out.valid       = 1'b1;
                result_out.taxel_index = idx_reg;
                result_out.taxel_value = ram_rdata;
                if (last_idx)
                begin
                    result_out.prox_level          = final_fields.prox_raw;
                    result_out.prox_change         = final_fields.prox_delta;
                    result_out.normal_force_mn     = final_fields.normal;
                    result_out.tangential_force_mn = final_fields.tangential;
                    result_out.direction_deg       = final_fields.direction;
                    result_out.direction_valid     = final_fields.direction_valid;
                    result_out.last                = 1'b1;
                end
            end
            default:
            begin
                idle = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SEQ_IDLE;
            idx_reg    <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
        end
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SEQ_SHOW |-> idx_reg <= LAST_TAXEL)
        else $error("taxel index past the last taxel");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done.valid |-> state_reg == SEQ_IDLE)
        else $error("frame graded while a burst is still running");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && result_out.last |=> state_reg == SEQ_IDLE)
        else $error("burst did not end after its last word");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SEQ_SHOW && out_take && !last_idx
        |=> state_reg == SEQ_SHOW && idx_reg == $past(idx_reg) + 5'd1)
        else $error("taxel index did not advance by one");

endmodule
